>>> hw/rtl/erac_pkg.sv
// ============================================================================
// erac_pkg
// Shared types, codes and constants for the edge recovery and attack
// controller: configuration and state records, sensor codes, speed values.
// ============================================================================
package erac_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_BACKUP_LEN_SIDE = 3'd0,
        CFG_BACKUP_LEN_BOTH = 3'd1,
        CFG_ROTATE_LEN      = 3'd2,
        CFG_BOTH_WINDOW     = 3'd3,
        CFG_LATCH_LEN       = 3'd4,
        CFG_MIDDLE_CONFIRM  = 3'd5,
        CFG_ZIGZAG_LEN      = 3'd6,
        CFG_RECOVERY_SPEED  = 3'd7
    } t_cfg_idx;

    // Edge sensor classes.
    localparam logic [1:0] EDGE_CLEAR = 2'd0;
    localparam logic [1:0] EDGE_BOTH  = 2'd1;
    localparam logic [1:0] EDGE_LEFT  = 2'd2;
    localparam logic [1:0] EDGE_RIGHT = 2'd3;

    // Enemy sectors.
    localparam logic [3:0] SEC_NONE            = 4'd0;
    localparam logic [3:0] SEC_LEFT            = 4'd1;
    localparam logic [3:0] SEC_LEFT_MID        = 4'd2;
    localparam logic [3:0] SEC_LEFT_MID_CLOSE  = 4'd3;
    localparam logic [3:0] SEC_MID_FAR         = 4'd4;
    localparam logic [3:0] SEC_MID_CLOSE       = 4'd5;
    localparam logic [3:0] SEC_RIGHT_MID_CLOSE = 4'd6;
    localparam logic [3:0] SEC_RIGHT_MID       = 4'd7;
    localparam logic [3:0] SEC_RIGHT           = 4'd8;
    localparam logic [3:0] SEC_FLAG_LEFT       = 4'd9;
    localparam logic [3:0] SEC_FLAG_RIGHT      = 4'd10;

    // Minimum dwell times in ms.
    localparam logic [31:0] MIN_BACK_DWELL = 32'd60;
    localparam logic [31:0] MIN_TURN_DWELL = 32'd80;

    // Wheel speeds.
    localparam logic signed [8:0] SPD_FULL     = 9'sd255;
    localparam logic signed [8:0] SPD_CRUISE   = 9'sd150;
    localparam logic signed [8:0] SPD_MID      = 9'sd200;
    localparam logic signed [8:0] SPD_ZIG_FWD  = 9'sd200;
    localparam logic signed [8:0] SPD_ZIG_BACK = -9'sd100;
    localparam logic signed [8:0] SPD_STOP     = 9'sd0;

    // Register reset values.
    localparam logic [15:0] RST_BACKUP_LEN_SIDE = 16'd200;
    localparam logic [15:0] RST_BACKUP_LEN_BOTH = 16'd250;
    localparam logic [15:0] RST_ROTATE_LEN      = 16'd80;
    localparam logic [15:0] RST_BOTH_WINDOW     = 16'd20;
    localparam logic [15:0] RST_LATCH_LEN       = 16'd30;
    localparam logic [15:0] RST_MIDDLE_CONFIRM  = 16'd20;
    localparam logic [15:0] RST_ZIGZAG_LEN      = 16'd250;
    localparam logic [7:0]  RST_RECOVERY_SPEED  = 8'd200;

    typedef struct packed {
        logic [15:0] backup_len_side;
        logic [15:0] backup_len_both;
        logic [15:0] rotate_len;
        logic [15:0] both_window;
        logic [15:0] latch_len;
        logic [15:0] middle_confirm;
        logic [15:0] zigzag_len;
        logic [7:0]  recovery_speed;
    } t_cfg;

    typedef struct packed {
        logic        recovering;
        logic        rotating_phase;
        logic        turn_left;
        logic        hit_was_both;
        logic [31:0] phase_start;
        logic        hit_pending;
        logic        pending_left;
        logic [31:0] pending_start;
        logic        latched;
        logic        latch_left;
        logic [31:0] latch_start;
        logic        middle_seen;
        logic [31:0] middle_start;
        logic        zig_left;
        logic        zig_started;
        logic [31:0] zig_start;
    } t_state;

    // A dwell is met when (elapsed - dwell) modulo 2^32 has its top bit clear.
    function automatic logic dwell_met(input logic [31:0] elapsed,
                                       input logic [31:0] dwell);
        logic [31:0] diff;
        diff = elapsed - dwell;
        return ~diff[31];
    endfunction

endpackage

>>> hw/rtl/erac_if.sv
// ============================================================================
// erac_if
// Valid/ready channels of the edge recovery and attack controller: the
// sensor tick channel and the wheel speed channel.
// ============================================================================

// Sensor tick channel.
interface erac_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic [1:0]  edge_class;
    logic [3:0]  enemy_sector;

    modport source (output valid, output now_ms, output edge_class,
                    output enemy_sector, input ready);
    modport sink   (input valid, input now_ms, input edge_class,
                    input enemy_sector, output ready);
endinterface

// Wheel speed channel.
interface erac_out_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] left_speed;
    logic signed [8:0] right_speed;

    modport source (output valid, output left_speed, output right_speed,
                    input ready);
    modport sink   (input valid, input left_speed, input right_speed,
                    output ready);
endinterface

>>> hw/rtl/erac_step.sv
// ============================================================================
// erac_step
// Decision logic for one tick: from the current state, the registers and
// the sensor fields it forms the next state and the two wheel speeds.
// ============================================================================
module erac_step
    import erac_pkg::*;
(
    input  t_cfg              i_cfg,
    input  t_state            i_state,
    input  logic [31:0]       i_now,
    input  logic [1:0]        i_edge,
    input  logic [3:0]        i_sector,
    output t_state            o_state,
    output logic signed [8:0] o_left,
    output logic signed [8:0] o_right
);

    t_state            st;
    logic              interrupt;
    logic              done;
    logic              start_rec;
    logic              rec_both;
    logic              rec_left;
    logic signed [8:0] spd;
    logic [31:0]       back_len;
    logic [31:0]       el_back;
    logic [31:0]       el_rot;
    logic [31:0]       el_pend;
    logic [31:0]       el_mid;
    logic [31:0]       el_latch;
    logic [31:0]       el_zig;
    logic signed [8:0] left;
    logic signed [8:0] right;

    always_comb begin
        st        = i_state;
        left      = SPD_STOP;
        right     = SPD_STOP;
        done      = 1'b0;
        start_rec = 1'b0;
        rec_both  = 1'b0;
        rec_left  = 1'b0;
        back_len  = '0;
        el_back   = '0;
        el_rot    = '0;
        el_pend   = '0;
        el_mid    = '0;
        el_latch  = '0;
        el_zig    = '0;
        spd       = {1'b0, i_cfg.recovery_speed};
        interrupt = (i_sector != SEC_NONE) && (i_edge == EDGE_CLEAR);

        // Edge recovery: back up, then rotate away, unless an enemy shows up.
        if (st.recovering && !interrupt) begin
            st.latched = 1'b0;
            if (!st.rotating_phase) begin
                el_back  = i_now - st.phase_start;
                back_len = {16'b0, st.hit_was_both ? i_cfg.backup_len_both
                                                   : i_cfg.backup_len_side};
                if (el_back < back_len || !dwell_met(el_back, MIN_BACK_DWELL)) begin
                    left  = -spd;
                    right = -spd;
                    done  = 1'b1;
                end else begin
                    st.rotating_phase = 1'b1;
                    st.phase_start    = i_now;
                end
            end
            if (!done) begin
                el_rot = i_now - st.phase_start;
                if (el_rot < {16'b0, i_cfg.rotate_len}
                        || !dwell_met(el_rot, MIN_TURN_DWELL)) begin
                    left  = st.turn_left ? -spd : spd;
                    right = st.turn_left ? spd : -spd;
                    done  = 1'b1;
                end
            end
        end
        if (st.recovering && !done) begin
            st.recovering     = 1'b0;
            st.rotating_phase = 1'b0;
            st.turn_left      = 1'b0;
        end

        // Pending one-side hit: wait for the second sensor or the window end.
        if (!done && st.hit_pending) begin
            if (!interrupt) begin
                if (i_edge == EDGE_BOTH) begin
                    start_rec = 1'b1;
                    rec_both  = 1'b1;
                    done      = 1'b1;
                end else begin
                    el_pend = i_now - st.pending_start;
                    if (el_pend >= {16'b0, i_cfg.both_window}) begin
                        start_rec = 1'b1;
                        rec_left  = st.pending_left;
                    end
                    done = 1'b1;
                end
            end else begin
                st.hit_pending = 1'b0;
            end
        end

        // New edge hit.
        if (!done) begin
            if (i_edge == EDGE_BOTH) begin
                start_rec = 1'b1;
                rec_both  = 1'b1;
                done      = 1'b1;
            end else if (i_edge == EDGE_LEFT || i_edge == EDGE_RIGHT) begin
                st.hit_pending   = 1'b1;
                st.pending_left  = (i_edge == EDGE_RIGHT);
                st.pending_start = i_now;
                done             = 1'b1;
            end
        end

        // Hard-turn latch toward a side enemy.
        if (!done) begin
            if (!st.latched && (i_sector == SEC_LEFT || i_sector == SEC_RIGHT)) begin
                st.latched     = 1'b1;
                st.latch_left  = (i_sector == SEC_LEFT);
                st.latch_start = i_now;
                st.middle_seen = 1'b0;
            end
            if (st.latched) begin
                if (i_sector >= SEC_LEFT_MID && i_sector <= SEC_RIGHT_MID) begin
                    if (!st.middle_seen) begin
                        st.middle_seen  = 1'b1;
                        st.middle_start = i_now;
                    end
                    el_mid = i_now - st.middle_start;
                    if (el_mid >= {16'b0, i_cfg.middle_confirm}) begin
                        st.latched = 1'b0;
                    end
                end else begin
                    st.middle_seen = 1'b0;
                end
                el_latch = i_now - st.latch_start;
                if (el_latch >= {16'b0, i_cfg.latch_len}) begin
                    st.latched = 1'b0;
                end
                if (st.latched) begin
                    left  = st.latch_left ? -SPD_FULL : SPD_FULL;
                    right = st.latch_left ? SPD_FULL : -SPD_FULL;
                    done  = 1'b1;
                end
            end
        end

        // Sector speed table and zigzag search.
        if (!done) begin
            case (i_sector) inside
                SEC_NONE: begin
                    if (!st.zig_started) begin
                        st.zig_started = 1'b1;
                        st.zig_start   = i_now;
                    end
                    el_zig = i_now - st.zig_start;
                    if (el_zig >= {16'b0, i_cfg.zigzag_len}) begin
                        st.zig_left  = ~st.zig_left;
                        st.zig_start = i_now;
                    end
                    left  = st.zig_left ? SPD_ZIG_BACK : SPD_ZIG_FWD;
                    right = st.zig_left ? SPD_ZIG_FWD : SPD_ZIG_BACK;
                end
                SEC_LEFT, SEC_FLAG_LEFT: begin
                    left  = -SPD_FULL;
                    right = SPD_FULL;
                end
                SEC_LEFT_MID: begin
                    left  = -SPD_CRUISE;
                    right = SPD_FULL;
                end
                SEC_LEFT_MID_CLOSE: begin
                    left  = SPD_MID;
                    right = SPD_FULL;
                end
                SEC_MID_FAR: begin
                    left  = SPD_CRUISE;
                    right = SPD_CRUISE;
                end
                SEC_MID_CLOSE: begin
                    left  = SPD_FULL;
                    right = SPD_FULL;
                end
                SEC_RIGHT_MID_CLOSE: begin
                    left  = SPD_FULL;
                    right = SPD_MID;
                end
                SEC_RIGHT_MID: begin
                    left  = SPD_FULL;
                    right = -SPD_CRUISE;
                end
                SEC_RIGHT, SEC_FLAG_RIGHT: begin
                    left  = SPD_FULL;
                    right = -SPD_FULL;
                end
                default: begin
                    left  = SPD_STOP;
                    right = SPD_STOP;
                end
            endcase
        end

        // Start of recovery: stop pending and latch, back up straight.
        if (start_rec) begin
            st.hit_was_both   = rec_both;
            st.turn_left      = rec_left;
            st.recovering     = 1'b1;
            st.rotating_phase = 1'b0;
            st.phase_start    = i_now;
            st.hit_pending    = 1'b0;
            st.latched        = 1'b0;
            left              = -spd;
            right             = -spd;
        end
    end

    assign o_state = st;
    assign o_left  = left;
    assign o_right = right;

endmodule

>>> hw/rtl/edge_recovery_attack_controller.sv
// ============================================================================
// edge_recovery_attack_controller
// Edge recovery, hard-turn latch, sector steering and zigzag search for a
// two-wheeled robot: one pair of signed wheel speeds per sensor tick.
// ============================================================================
// Usage:
//   i_item carries one sensor tick (time in ms, edge class, enemy sector);
//   o_result carries one pair of signed 9-bit wheel speeds per tick.
//   A transfer happens on a rising edge with valid and ready both high.
//   The tick is captured in an input register; the decision logic then
//   writes the result register and the controller state from it. A new
//   tick can be taken every cycle while the receiver does not stall. The
//   state update is a single register step, so back-to-back ticks see
//   each other's effects in order.
//   When the receiver stalls, the result register holds and the input
//   register keeps one more tick; i_item.ready then drops until the
//   result is taken.
//   The registers are written through i_cfg_we/i_cfg_idx/i_cfg_data while
//   no tick is in flight. Synchronous reset (i_rst_n low) loads the default
//   register values, clears the controller state and empties both stages.
// ============================================================================
module edge_recovery_attack_controller
    import erac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    erac_in_if.sink     i_item,
    erac_out_if.source  o_result,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_cfg              r_cfg;
    t_state            r_state;
    t_state            n_state;
    logic              r_in_valid;
    logic [31:0]       r_now;
    logic [1:0]        r_edge;
    logic [3:0]        r_sector;
    logic              r_out_valid;
    logic signed [8:0] r_left;
    logic signed [8:0] r_right;
    logic signed [8:0] n_left;
    logic signed [8:0] n_right;
    logic              adv;
    logic              fire;
    logic              in_xfer;

    // Handshake: the result register frees up when empty or being taken.
    assign adv     = !r_out_valid || o_result.ready;
    assign fire    = r_in_valid && adv;
    assign in_xfer = i_item.valid && i_item.ready;

    assign i_item.ready         = !r_in_valid || adv;
    assign o_result.valid       = r_out_valid;
    assign o_result.left_speed  = r_left;
    assign o_result.right_speed = r_right;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.backup_len_side <= RST_BACKUP_LEN_SIDE;
            r_cfg.backup_len_both <= RST_BACKUP_LEN_BOTH;
            r_cfg.rotate_len      <= RST_ROTATE_LEN;
            r_cfg.both_window     <= RST_BOTH_WINDOW;
            r_cfg.latch_len       <= RST_LATCH_LEN;
            r_cfg.middle_confirm  <= RST_MIDDLE_CONFIRM;
            r_cfg.zigzag_len      <= RST_ZIGZAG_LEN;
            r_cfg.recovery_speed  <= RST_RECOVERY_SPEED;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BACKUP_LEN_SIDE: r_cfg.backup_len_side <= i_cfg_data;
                CFG_BACKUP_LEN_BOTH: r_cfg.backup_len_both <= i_cfg_data;
                CFG_ROTATE_LEN:      r_cfg.rotate_len      <= i_cfg_data;
                CFG_BOTH_WINDOW:     r_cfg.both_window     <= i_cfg_data;
                CFG_LATCH_LEN:       r_cfg.latch_len       <= i_cfg_data;
                CFG_MIDDLE_CONFIRM:  r_cfg.middle_confirm  <= i_cfg_data;
                CFG_ZIGZAG_LEN:      r_cfg.zigzag_len      <= i_cfg_data;
                CFG_RECOVERY_SPEED:  r_cfg.recovery_speed  <= i_cfg_data[7:0];
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

    // Input register stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_now    <= i_item.now_ms;
            r_edge   <= i_item.edge_class;
            r_sector <= i_item.enemy_sector;
        end
    end

    // Decision logic for the registered tick.
    erac_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_now    (r_now),
        .i_edge   (r_edge),
        .i_sector (r_sector),
        .o_state  (n_state),
        .o_left   (n_left),
        .o_right  (n_right)
    );

    // Controller state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

endmodule
